FILE: rtl/gppe_pkg.sv
// ----------------------------------------------------------------------------
// gppe_pkg
// Shared codes, constants and controller/datapath handshake types for the
// GF(2) phase polynomial engine.
// ----------------------------------------------------------------------------
package gppe_pkg;

    localparam logic [2:0] MODE_TOGGLE = 3'd0;
    localparam logic [2:0] MODE_CCZ    = 3'd1;
    localparam logic [2:0] MODE_CNOT   = 3'd2;
    localparam logic [2:0] MODE_QUERY  = 3'd3;
    localparam logic [2:0] MODE_HASH   = 3'd4;

    // config register index (byte address bit 2)
    localparam logic CFG_LIVE_VARS = 1'b0;
    localparam logic [2:0] LIVE_VARS_RESET = 3'd6;

    // FNV-1a 64; prime = 2^40 + 0x1B3
    localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
    localparam int          FNV_SHIFT    = 40;
    localparam logic [63:0] FNV_PRIME_LO = 64'd435;

    typedef struct packed {
        logic accept;   // item transfer: apply op, latch flags
        logic build;    // hash: shift one term into the columns
        logic sort;     // hash: one compare/rotate step of the column ring
        logic fold;     // hash: one FNV fold step
        logic finish;   // load output register
    } gppe_cmd_t;

    typedef struct packed {
        logic hash_go;    // item is a hash of a non-empty polynomial
        logic idx_last;   // term walk at last index
        logic sort_last;  // last step of last sort pass
        logic out_free;   // output register can take a result
    } gppe_sts_t;

endpackage

FILE: rtl/gppe_if.sv
// ----------------------------------------------------------------------------
// gppe_in_if / gppe_out_if
// Valid/ready channels carrying the item and result payloads.
// ----------------------------------------------------------------------------
interface gppe_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [5:0] term;
    logic [2:0] index_a;
    logic [2:0] index_b;
    logic [2:0] index_c;

    modport source (output valid, mode, term, index_a, index_b, index_c, input ready);
    modport sink   (input valid, mode, term, index_a, index_b, index_c, output ready);
endinterface

interface gppe_out_if;
    logic        valid;
    logic        ready;
    logic        present;
    logic [6:0]  term_count;
    logic        is_empty;
    logic [63:0] hash_value;
    logic        error;

    modport source (output valid, present, term_count, is_empty, hash_value, error,
                    input ready);
    modport sink   (input valid, present, term_count, is_empty, hash_value, error,
                    output ready);
endinterface

FILE: rtl/gppe_ctrl.sv
// ----------------------------------------------------------------------------
// gppe_ctrl
// Sequencer: accepts items, steps the hash phases, loads results.
// ----------------------------------------------------------------------------
module gppe_ctrl
    import gppe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  gppe_sts_t sts,
    output gppe_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FIN   = 5'b00010,
        S_BUILD = 5'b00100,
        S_SORT  = 5'b01000,
        S_FOLD  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.hash_go ? S_BUILD : S_FIN;
                end
            end
            S_BUILD:
            begin
                cmd.build = 1'b1;
                if (sts.idx_last)
                    state_next = S_SORT;
            end
            S_SORT:
            begin
                cmd.sort = 1'b1;
                if (sts.sort_last)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                if (sts.idx_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> sts.out_free)
        else $error("result loaded while output register busy");

    a_plain_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !sts.hash_go) |=> (state_reg == S_FIN))
        else $error("plain item did not go straight to finish");

    a_build_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUILD) |=> (state_reg == S_BUILD || state_reg == S_SORT))
        else $error("column build left early");

    a_fold_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FOLD && sts.idx_last) |=> (state_reg == S_FIN))
        else $error("fold did not end in finish");

endmodule

FILE: rtl/gppe_dp.sv
// ----------------------------------------------------------------------------
// gppe_dp
// Term bitmap, rewrites applied on item accept, hash column ring and FNV folder,
// output register.
// ----------------------------------------------------------------------------
module gppe_dp
    import gppe_pkg::*;
#(
    parameter int MAX_VARS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [2:0]  live_vars,
    input  logic [2:0]  mode,
    input  logic [5:0]  term,
    input  logic [2:0]  index_a,
    input  logic [2:0]  index_b,
    input  logic [2:0]  index_c,
    input  gppe_cmd_t   cmd,
    output gppe_sts_t   sts,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        present,
    output logic [6:0]  term_count,
    output logic        is_empty,
    output logic [63:0] hash_value,
    output logic        error
);

    localparam int TW       = MAX_VARS;
    localparam int MAP_BITS = 1 << MAX_VARS;
    localparam int STEP_W   = $clog2(MAX_VARS + 1);
    localparam int PASSES   = (MAX_VARS > 1) ? MAX_VARS - 1 : 1;

    logic [MAP_BITS-1:0] map_reg, map_next;
    logic [6:0]          count_reg;
    logic                present_reg, err_reg, hash_mode_reg;
    logic [63:0]         hash_reg;
    logic [TW-1:0]       idx_reg;
    logic [STEP_W-1:0]   step_reg, pass_reg;

    // column ring: value and original variable index
    logic [MAP_BITS-1:0] col_reg [TW];
    logic [2:0]          tag_reg [TW];
    logic [MAP_BITS-1:0] carry_reg;
    logic [2:0]          carry_tag_reg;

    logic [2:0]    n;
    logic [TW-1:0] mask_n, ma, mb, mc;
    logic          ccz_ok, cnot_ok, op_err, op_present;
    logic [MAP_BITS-1:0] cnot_vec, ccz_vec;

    assign n      = (live_vars > 3'(MAX_VARS)) ? 3'(MAX_VARS) : live_vars;
    assign mask_n = ~({TW{1'b1}} << n);
    assign ma     = TW'(1) << index_a;
    assign mb     = TW'(1) << index_b;
    assign mc     = TW'(1) << index_c;

    assign ccz_ok  = (index_a < n) && (index_b < n) && (index_c < n);
    assign cnot_ok = (index_a < n) && (index_b < n) && (index_a != index_b);

    assign ccz_vec = (MAP_BITS'(1) << (ma | mb | mc)) ^ (MAP_BITS'(1) << (ma | mb))
                   ^ (MAP_BITS'(1) << (ma | mc)) ^ (MAP_BITS'(1) << (mb | mc))
                   ^ (MAP_BITS'(1) << ma) ^ (MAP_BITS'(1) << mb)
                   ^ (MAP_BITS'(1) << mc);

    // inverse CNOT is a bit permutation: target set flips the control bit
    always_comb
    begin
        logic [TW-1:0] tv;
        logic [TW-1:0] src;
        for (int t = 0; t < MAP_BITS; t++)
        begin
            tv  = TW'(t);
            src = tv ^ ((((tv >> index_b) & TW'(1)) != '0) ? ma : '0);
            cnot_vec[t] = map_reg[src];
        end
    end

    always_comb
    begin
        map_next   = map_reg;
        op_err     = 1'b0;
        op_present = 1'b0;
        case (mode)
            MODE_TOGGLE:
                map_next = map_reg ^ (MAP_BITS'(1) << (term[TW-1:0] & mask_n));
            MODE_CCZ:
            begin
                if (ccz_ok)
                    map_next = map_reg ^ ccz_vec;
                else
                    op_err = 1'b1;
            end
            MODE_CNOT:
            begin
                if (cnot_ok)
                    map_next = cnot_vec;
                else
                    op_err = 1'b1;
            end
            MODE_QUERY:
                op_present = ((term >> MAX_VARS) == 6'd0) && map_reg[term[TW-1:0]];
            MODE_HASH:
                map_next = map_reg;
            default:
                op_err = 1'b1;
        endcase
    end

    // fold: walk k as {w, stale high bits}; map w back through the column order
    logic [2:0]    lsh;
    logic [TW-1:0] fold_w, fold_hi, fold_lo, fold_t;
    logic [63:0]   fold_x;
    logic          sort_gt;

    assign lsh     = 3'(MAX_VARS) - n;
    assign fold_w  = idx_reg >> lsh;
    assign fold_hi = idx_reg & ~({TW{1'b1}} << lsh);

    always_comb
    begin
        fold_lo = '0;
        for (int v = 0; v < TW; v++)
        begin
            if (3'(v) < n)
                fold_lo = fold_lo | (TW'(fold_w[v]) << tag_reg[v]);
        end
    end

    assign fold_t  = fold_lo | (fold_hi << n);
    assign fold_x  = hash_reg ^ 64'(fold_w);
    assign sort_gt = col_reg[0] > carry_reg;

    assign sts.hash_go   = (mode == MODE_HASH) && (count_reg != 7'd0);
    assign sts.idx_last  = &idx_reg;
    assign sts.sort_last = (step_reg == STEP_W'(MAX_VARS)) && (pass_reg == STEP_W'(PASSES - 1));
    assign sts.out_free  = !out_valid || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg   <= '0;
            count_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
                map_reg <= map_next;
            if (cmd.finish)
            begin
                count_reg <= 7'($countones(map_reg));
                out_valid <= 1'b1;
            end
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            present_reg   <= op_present;
            err_reg       <= op_err;
            hash_mode_reg <= (mode == MODE_HASH);
            hash_reg      <= (count_reg == 7'd0) ? 64'd0 : FNV_BASIS;
            idx_reg       <= '0;
            step_reg      <= '0;
            pass_reg      <= '0;
            // unused columns sit at all ones so they sort last
            for (int v = 0; v < TW; v++)
            begin
                col_reg[v] <= (3'(v) < n) ? '0 : '1;
                tag_reg[v] <= 3'(v);
            end
        end
        if (cmd.build)
        begin
            idx_reg <= idx_reg + TW'(1);
            if (map_reg[idx_reg])
            begin
                for (int v = 0; v < TW; v++)
                begin
                    if (3'(v) < n)
                        col_reg[v] <= {col_reg[v][MAP_BITS-2:0], idx_reg[v]};
                end
            end
        end
        if (cmd.sort)
        begin
            // bubble pass through a ring: pop head, push the smaller, carry the larger
            for (int v = 0; v < TW - 1; v++)
            begin
                col_reg[v] <= col_reg[v+1];
                tag_reg[v] <= tag_reg[v+1];
            end
            if (step_reg == '0)
            begin
                carry_reg     <= col_reg[0];
                carry_tag_reg <= tag_reg[0];
                col_reg[TW-1] <= col_reg[(TW > 1) ? 1 : 0];
                tag_reg[TW-1] <= tag_reg[(TW > 1) ? 1 : 0];
            end
            else if (step_reg == STEP_W'(MAX_VARS))
            begin
                col_reg[TW-1] <= carry_reg;
                tag_reg[TW-1] <= carry_tag_reg;
            end
            else
            begin
                col_reg[TW-1] <= sort_gt ? carry_reg : col_reg[0];
                tag_reg[TW-1] <= sort_gt ? carry_tag_reg : tag_reg[0];
                carry_reg     <= sort_gt ? col_reg[0] : carry_reg;
                carry_tag_reg <= sort_gt ? tag_reg[0] : carry_tag_reg;
            end
            if (step_reg == STEP_W'(MAX_VARS))
            begin
                step_reg <= '0;
                pass_reg <= pass_reg + STEP_W'(1);
            end
            else
                step_reg <= step_reg + STEP_W'(1);
        end
        if (cmd.fold)
        begin
            idx_reg <= idx_reg + TW'(1);
            if (map_reg[fold_t])
                hash_reg <= (fold_x << FNV_SHIFT) + fold_x * FNV_PRIME_LO;
        end
        if (cmd.finish)
        begin
            present    <= present_reg;
            term_count <= 7'($countones(map_reg));
            is_empty   <= (map_reg == '0);
            hash_value <= hash_mode_reg ? hash_reg : 64'd0;
            error      <= err_reg;
        end
    end

endmodule

FILE: rtl/gf2_phase_polynomial_engine.sv
// ----------------------------------------------------------------------------
// gf2_phase_polynomial_engine
// GF(2) phase polynomial store with toggle, CCZ, inverse CNOT, query and
// canonical hash operations.
// ----------------------------------------------------------------------------
// Toggle, CCZ, CNOT, query and bad modes go from the input transfer through S_FIN
//   to the result; the bitmap rewrite is done at the input transfer edge.
// Hash: an empty polynomial goes straight to S_FIN; else S_BUILD, S_SORT and S_FOLD
//   run in order, set by the serial term walks and one column comparator.
// Throughput: one item in flight; next item taken once the result is loaded.
// Reset: bitmap cleared (empty polynomial), live_vars = 6, no result pending.
module gf2_phase_polynomial_engine
    import gppe_pkg::*;
#(
    parameter int MAX_VARS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    gppe_in_if.sink     in_ch,
    gppe_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration: one register, index taken from byte address bit 2
    logic [2:0] live_vars_reg;
    logic       cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2] == CFG_LIVE_VARS) ? {29'd0, live_vars_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            live_vars_reg <= LIVE_VARS_RESET;
        else if (cfg_we && paddr[2] == CFG_LIVE_VARS)
            live_vars_reg <= pwdata[2:0];
    end

    gppe_cmd_t cmd;
    gppe_sts_t sts;

    // sequencer
    gppe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // bitmap, hash machinery and output register
    gppe_dp #(
        .MAX_VARS (MAX_VARS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .live_vars  (live_vars_reg),
        .mode       (in_ch.mode),
        .term       (in_ch.term),
        .index_a    (in_ch.index_a),
        .index_b    (in_ch.index_b),
        .index_c    (in_ch.index_c),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .present    (out_ch.present),
        .term_count (out_ch.term_count),
        .is_empty   (out_ch.is_empty),
        .hash_value (out_ch.hash_value),
        .error      (out_ch.error)
    );

endmodule
